>>> src/lgts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lgts_pkg;

    localparam int MAX_TOPICS = 256;
    localparam int VOCAB_SIZE = 4096;
    localparam int COUNT_BITS = 24;

    localparam int TOPIC_W    = $clog2(MAX_TOPICS);
    localparam int WORD_W     = $clog2(VOCAB_SIZE);
    localparam int KCFG_W     = 9;
    localparam int FRAC_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int ALPHA_W    = 32;
    localparam int VB_W       = 48;
    localparam int RAND_W     = 32;
    localparam int WEIGHT_W   = 64;
    localparam int HALF_W     = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Q.16 term widths: doc and word terms, divisor and their exact product.
    localparam int TERM_W = COUNT_BITS + FRAC_W + 1;
    localparam int DIV_W  = (((TOTAL_W + FRAC_W) > VB_W) ? (TOTAL_W + FRAC_W) : VB_W) + 1;
    localparam int PROD_W = 2 * TERM_W;
    localparam int STEP_W = $clog2(PROD_W);
    localparam int WT_DEPTH = VOCAB_SIZE * MAX_TOPICS;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_WORD  = 2'd0,
        CMD_LOAD_TOTAL = 2'd1,
        CMD_LOAD_DOC   = 2'd2,
        CMD_SAMPLE     = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_UNDERFLOW = 2'd1,
        STS_RANGE     = 2'd2
    } sts_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOPICS = 2'd0,
        REG_ALPHA  = 2'd1,
        REG_BETA   = 2'd2,
        REG_VBETA  = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_REJECT,
        OP_RD_OLD,
        OP_DEC_OLD,
        OP_RD_K,
        OP_TERMS,
        OP_MUL,
        OP_ACC,
        OP_DIV,
        OP_ACCUM,
        OP_THR_HI,
        OP_THR_LO,
        OP_THR_ADD,
        OP_SRCH_RD,
        OP_PICK,
        OP_RD_CHOSEN,
        OP_INC
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD_OLD,
        S_DEC_OLD,
        S_RD_K,
        S_TERMS,
        S_MUL,
        S_ACC,
        S_DIV,
        S_ACCUM,
        S_THR_HI,
        S_THR_LO,
        S_THR_ADD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_CHOSEN,
        S_INC,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t             op;
        logic [TOPIC_W-1:0] k;
        logic [1:0]         sel;
    } dp_ctl_t;

    typedef struct packed {
        cmd_t               command;
        logic               in_range;
        logic               hit;
        logic [TOPIC_W-1:0] k_last;
    } dp_sts_t;

endpackage

>>> src/lda_gibbs_topic_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler
// Draws one token's topic by collapsed Gibbs sampling over loaded counts.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Payload
// -------   ---------             -------
// command   start / busy          command, word, topic, count_value,
//                                 random_fraction
// result    done (one cycle)      new_topic, status
// config    cfg_write             cfg_index, cfg_data
//
// A transaction is accepted at a clock edge where start is high and busy is
// low. For each topic in use, a sample forms the weight with the split
// 32x32 multiplier and the one-bit-per-cycle divider; the search then reads
// the cumulative weights in topic order until one reaches the threshold or
// the last topic in use is read.
// The result is shown for exactly one cycle with done high; the receiver
// cannot stall it. Reset clears the controller and presets the configuration
// only; the count stores stay undefined until loaded and need no clearing pass.
//
module lda_gibbs_topic_sampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [lgts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lgts_pkg::CMD_W-1:0]           command,
    input  logic [lgts_pkg::WORD_W-1:0]          word,
    input  logic [lgts_pkg::TOPIC_W-1:0]         topic,
    input  logic [lgts_pkg::COUNT_BITS-1:0]      count_value,
    input  logic [lgts_pkg::RAND_W-1:0]          random_fraction,
    output logic                                 done,
    output logic [lgts_pkg::TOPIC_W-1:0]         new_topic,
    output logic [lgts_pkg::STATUS_W-1:0]        status
);
    import lgts_pkg::*;

    // The controller only steps the sequence; all arithmetic and the
    // stores live in the datapath.
    dp_ctl_t ctl;
    dp_sts_t sts;

    lgts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // The datapath latches the command transaction on capture and holds the
    // result registers, which stay stable while done is shown.
    lgts_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .word            (word),
        .topic           (topic),
        .count_value     (count_value),
        .random_fraction (random_fraction),
        .ctl             (ctl),
        .sts             (sts),
        .new_topic       (new_topic),
        .status          (status)
    );

endmodule

>>> src/lgts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler controller
// Sequences loads and the sample walk: decrement, weights, threshold, search, add-back.
// ----------------------------------------------------------------------------
module lgts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lgts_pkg::dp_sts_t sts,
    output lgts_pkg::dp_ctl_t ctl,
    output logic              busy,
    output logic              done
);
    import lgts_pkg::*;

    state_t              state_reg, state_next;
    logic [TOPIC_W-1:0]  k_reg, k_next;
    logic [1:0]          sel_reg, sel_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            sel_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    // Next state and loop counters.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (sts.command == CMD_SAMPLE && sts.in_range)
                    state_next = S_RD_OLD;
                else
                    state_next = S_DONE;
            end
            S_RD_OLD:  state_next = S_DEC_OLD;
            S_DEC_OLD:
            begin
                k_next     = '0;
                state_next = S_RD_K;
            end
            S_RD_K:    state_next = S_TERMS;
            S_TERMS:
            begin
                sel_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:     state_next = S_ACC;
            S_ACC:
            begin
                if (sel_reg == 2'd3)
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(PROD_W - 1))
                    state_next = S_ACCUM;
                else
                    step_next = step_reg + 1'b1;
            end
            S_ACCUM:
            begin
                if (k_reg == sts.k_last)
                    state_next = S_THR_HI;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD_K;
                end
            end
            S_THR_HI:  state_next = S_THR_LO;
            S_THR_LO:  state_next = S_THR_ADD;
            S_THR_ADD:
            begin
                k_next     = '0;
                state_next = S_SRCH_RD;
            end
            S_SRCH_RD: state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (sts.hit || k_reg == sts.k_last)
                    state_next = S_RD_CHOSEN;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_RD_CHOSEN: state_next = S_INC;
            S_INC:       state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        ctl.op  = OP_NONE;
        ctl.k   = k_reg;
        ctl.sel = sel_reg;
        busy    = 1'b1;
        done    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                    ctl.op = OP_CAPTURE;
            end
            S_DECODE:
            begin
                if (!sts.in_range)
                    ctl.op = OP_REJECT;
                else if (sts.command != CMD_SAMPLE)
                    ctl.op = OP_LOAD;
            end
            S_RD_OLD:    ctl.op = OP_RD_OLD;
            S_DEC_OLD:   ctl.op = OP_DEC_OLD;
            S_RD_K:      ctl.op = OP_RD_K;
            S_TERMS:     ctl.op = OP_TERMS;
            S_MUL:       ctl.op = OP_MUL;
            S_ACC:       ctl.op = OP_ACC;
            S_DIV:       ctl.op = OP_DIV;
            S_ACCUM:     ctl.op = OP_ACCUM;
            S_THR_HI:    ctl.op = OP_THR_HI;
            S_THR_LO:    ctl.op = OP_THR_LO;
            S_THR_ADD:   ctl.op = OP_THR_ADD;
            S_SRCH_RD:   ctl.op = OP_SRCH_RD;
            S_SRCH_CMP:
            begin
                if (sts.hit || k_reg == sts.k_last)
                    ctl.op = OP_PICK;
            end
            S_RD_CHOSEN: ctl.op = OP_RD_CHOSEN;
            S_INC:       ctl.op = OP_INC;
            S_DONE:      done = 1'b1;
            default:     ctl.op = OP_NONE;
        endcase
    end

endmodule

>>> src/lgts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler datapath
// Configuration, count stores, shared multiplier, serial divider, search.
// ----------------------------------------------------------------------------
module lgts_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [lgts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [lgts_pkg::CMD_W-1:0]           command,
    input  logic [lgts_pkg::WORD_W-1:0]          word,
    input  logic [lgts_pkg::TOPIC_W-1:0]         topic,
    input  logic [lgts_pkg::COUNT_BITS-1:0]      count_value,
    input  logic [lgts_pkg::RAND_W-1:0]          random_fraction,
    input  lgts_pkg::dp_ctl_t                    ctl,
    output lgts_pkg::dp_sts_t                    sts,
    output logic [lgts_pkg::TOPIC_W-1:0]         new_topic,
    output logic [lgts_pkg::STATUS_W-1:0]        status
);
    import lgts_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration registers.
    logic [KCFG_W-1:0]  tiu_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] beta_reg;
    logic [VB_W-1:0]    vbeta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg   <= KCFG_W'(100);
            alpha_reg <= ALPHA_W'(32768);
            beta_reg  <= ALPHA_W'(6554);
            vbeta_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TOPICS: tiu_reg   <= cfg_data[KCFG_W-1:0];
                REG_ALPHA:  alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_BETA:   beta_reg  <= cfg_data[ALPHA_W-1:0];
                REG_VBETA:  vbeta_reg <= cfg_data[VB_W-1:0];
                default:    tiu_reg   <= tiu_reg;
            endcase
        end
    end

    // Transaction and working registers.
    cmd_t                  cmd_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [TOPIC_W-1:0]    topic_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [RAND_W-1:0]     rnd_reg;
    logic [TERM_W-1:0]     dt_reg, wt_reg;
    logic [DIV_W-1:0]      dv_reg;
    logic [2*HALF_W-1:0]   mult_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [WEIGHT_W-1:0]   quo_reg;
    logic                  ovf_reg;
    logic [WEIGHT_W-1:0]   sum_reg;
    logic [WEIGHT_W-1:0]   thr_reg;
    logic [TOPIC_W-1:0]    chosen_reg;
    logic [TOPIC_W-1:0]    new_topic_reg;
    sts_code_t             status_reg;

    // Memory read data.
    logic [COUNT_BITS-1:0] doc_rd_reg;
    logic [COUNT_BITS-1:0] wtc_rd_reg;
    logic [TOTAL_W-1:0]    tot_rd_reg;
    logic [WEIGHT_W-1:0]   cw_rd_reg;

    // Effective topic count and range checks.
    logic [KCFG_W-1:0] k_eff;
    logic              load_ok, sample_ok;

    always_comb
    begin
        if (tiu_reg == '0)
            k_eff = KCFG_W'(1);
        else if (int'(tiu_reg) > MAX_TOPICS)
            k_eff = KCFG_W'(MAX_TOPICS);
        else
            k_eff = tiu_reg;
        load_ok   = (int'(word_reg) < VOCAB_SIZE) && (int'(topic_reg) < MAX_TOPICS);
        sample_ok = (int'(word_reg) < VOCAB_SIZE) && (int'(topic_reg) < int'(k_eff));
    end

    assign sts.command  = cmd_reg;
    assign sts.in_range = (cmd_reg == CMD_SAMPLE) ? sample_ok : load_ok;
    assign sts.hit      = (cw_rd_reg >= thr_reg);
    assign sts.k_last   = TOPIC_W'(k_eff - 1'b1);

    // Shared 32 x 32 multiplier operands.
    logic [2*HALF_W-1:0] dt64, wt64;
    logic [HALF_W-1:0]   mul_a, mul_b;

    assign dt64 = (2*HALF_W)'(dt_reg);
    assign wt64 = (2*HALF_W)'(wt_reg);

    always_comb
    begin
        case (ctl.op)
            OP_THR_HI:
            begin
                mul_a = sum_reg[2*HALF_W-1:HALF_W];
                mul_b = rnd_reg;
            end
            OP_THR_LO:
            begin
                mul_a = sum_reg[HALF_W-1:0];
                mul_b = rnd_reg;
            end
            default:
            begin
                mul_a = ctl.sel[1] ? dt64[2*HALF_W-1:HALF_W] : dt64[HALF_W-1:0];
                mul_b = ctl.sel[0] ? wt64[2*HALF_W-1:HALF_W] : wt64[HALF_W-1:0];
            end
        endcase
    end

    // Partial product alignment: low x low, two cross terms, high x high.
    logic [PROD_W-1:0] pp_aligned;

    always_comb
    begin
        case (ctl.sel)
            2'd0:    pp_aligned = PROD_W'({64'b0, mult_reg});
            2'd3:    pp_aligned = PROD_W'({64'b0, mult_reg} << 64);
            default: pp_aligned = PROD_W'({64'b0, mult_reg} << 32);
        endcase
    end

    // One restoring division step.
    logic [DIV_W:0]  rem_shift;
    logic            q_bit;
    logic [DIV_W:0]  rem_diff;

    assign rem_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, dv_reg});
    assign rem_diff  = rem_shift - {1'b0, dv_reg};

    // Term and saturating running sum.
    logic [WEIGHT_W-1:0] term;
    logic [WEIGHT_W:0]   sum_wide;
    logic [WEIGHT_W-1:0] sum_next;

    always_comb
    begin
        if (dv_reg == '0)
            term = '0;
        else if (ovf_reg)
            term = '1;
        else
            term = quo_reg;
        sum_wide = {1'b0, sum_reg} + {1'b0, term};
        sum_next = sum_wide[WEIGHT_W] ? '1 : sum_wide[WEIGHT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_CAPTURE:
            begin
                cmd_reg       <= cmd_t'(command);
                word_reg      <= word;
                topic_reg     <= topic;
                count_reg     <= count_value;
                rnd_reg       <= random_fraction;
                new_topic_reg <= '0;
                status_reg    <= STS_OK;
            end
            OP_REJECT:
                status_reg <= STS_RANGE;
            OP_DEC_OLD:
            begin
                sum_reg <= '0;
                if (doc_rd_reg == '0)
                    status_reg <= STS_UNDERFLOW;
            end
            OP_TERMS:
            begin
                dt_reg   <= TERM_W'({doc_rd_reg, FRAC_W'(0)}) + TERM_W'(alpha_reg);
                wt_reg   <= TERM_W'({wtc_rd_reg, FRAC_W'(0)}) + TERM_W'(beta_reg);
                dv_reg   <= DIV_W'({tot_rd_reg, FRAC_W'(0)}) + DIV_W'(vbeta_reg);
                prod_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            OP_MUL, OP_THR_HI:
                mult_reg <= mul_a * mul_b;
            OP_ACC:
                prod_reg <= prod_reg + pp_aligned;
            OP_DIV:
            begin
                prod_reg <= prod_reg << 1;
                rem_reg  <= q_bit ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                quo_reg  <= {quo_reg[WEIGHT_W-2:0], q_bit};
                ovf_reg  <= ovf_reg | quo_reg[WEIGHT_W-1];
            end
            OP_ACCUM:
                sum_reg <= sum_next;
            OP_THR_LO:
            begin
                thr_reg  <= mult_reg;
                mult_reg <= mul_a * mul_b;
            end
            OP_THR_ADD:
                thr_reg <= thr_reg + WEIGHT_W'(mult_reg[2*HALF_W-1:HALF_W]);
            OP_PICK:
            begin
                chosen_reg    <= ctl.k;
                new_topic_reg <= ctl.k;
            end
            default:
                ovf_reg <= ovf_reg;
        endcase
    end

    // Document topic counts.
    logic [COUNT_BITS-1:0] doc_mem [MAX_TOPICS];
    logic [TOPIC_W-1:0]    doc_raddr, doc_waddr;
    logic [COUNT_BITS-1:0] doc_wdata;
    logic                  doc_we;

    always_comb
    begin
        doc_we    = 1'b0;
        doc_waddr = topic_reg;
        doc_wdata = count_reg;
        case (ctl.op)
            OP_LOAD:
                doc_we = (cmd_reg == CMD_LOAD_DOC);
            OP_DEC_OLD:
            begin
                doc_we    = (doc_rd_reg != '0);
                doc_wdata = doc_rd_reg - 1'b1;
            end
            OP_INC:
            begin
                doc_we    = (doc_rd_reg != COUNT_MAX);
                doc_waddr = chosen_reg;
                doc_wdata = doc_rd_reg + 1'b1;
            end
            default:
                doc_we = 1'b0;
        endcase
        case (ctl.op)
            OP_RD_OLD:    doc_raddr = topic_reg;
            OP_RD_CHOSEN: doc_raddr = chosen_reg;
            default:      doc_raddr = ctl.k;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (doc_we)
            doc_mem[doc_waddr] <= doc_wdata;
        doc_rd_reg <= doc_mem[doc_raddr];
    end

    // Word-topic counts, addressed by word and topic.
    logic [COUNT_BITS-1:0] wtc_mem [WT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD && cmd_reg == CMD_LOAD_WORD)
            wtc_mem[{word_reg, topic_reg}] <= count_reg;
        wtc_rd_reg <= wtc_mem[{word_reg, ctl.k}];
    end

    // Topic totals.
    logic [TOTAL_W-1:0] tot_mem [MAX_TOPICS];

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD && cmd_reg == CMD_LOAD_TOTAL)
            tot_mem[topic_reg] <= TOTAL_W'(count_reg);
        tot_rd_reg <= tot_mem[ctl.k];
    end

    // Cumulative weights.
    logic [WEIGHT_W-1:0] cw_mem [MAX_TOPICS];

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_ACCUM)
            cw_mem[ctl.k] <= sum_next;
        cw_rd_reg <= cw_mem[ctl.k];
    end

    assign new_topic = new_topic_reg;
    assign status    = status_reg;

endmodule
